// File: hdl/nwcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwcf_pkg: shared types and constants of the nearest wire channel finder
// Field layout, register indexes, shared multiply unit command and wire entry.
// ----------------------------------------------------------------------------
package nwcf_pkg;

  // default geometry
  localparam int DEF_MAX_PLANES = 3;
  localparam int DEF_MAX_WIRES  = 4096;

  // field widths
  localparam int NUM_AXES   = 3;
  localparam int COORD_W    = 32;
  localparam int CHAN_W     = 14;
  localparam int LEN_W      = 64;
  localparam int CE_W       = 31;
  localparam int PCNT_W     = 2;
  localparam int WCNT_W     = 13;
  localparam int PIDX_W     = 2;
  localparam int WIDX_W     = 12;
  localparam int PLANE_REGS = 3;

  // input item packing, lowest bit first
  localparam int F_PLANE_LSB = 0;
  localparam int F_WIRE_LSB  = F_PLANE_LSB + PIDX_W;
  localparam int F_PT_LSB    = F_WIRE_LSB + WIDX_W;
  localparam int F_DIR_LSB   = F_PT_LSB + NUM_AXES * COORD_W;
  localparam int F_CHAN_LSB  = F_DIR_LSB + NUM_AXES * COORD_W;
  localparam int IN_BITS     = F_CHAN_LSB + CHAN_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((CHAN_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CE_RESET   = 123;
  localparam int PCNT_RESET = 3;

  // shared multiply-accumulate unit
  localparam int OP_W    = 34;
  localparam int PROD_W  = 2 * OP_W;
  localparam int LIMB_W  = 32;
  localparam int N_LIMBS = 5;
  localparam int N_W     = N_LIMBS * LIMB_W;
  localparam int D_LIMBS = LEN_W / LIMB_W;
  localparam int ACC_W   = 196;
  localparam int SHIFT_W = 3;

  // item kind carried in tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOSE_ENOUGH = 3'd0,
    REG_PLANE_COUNT  = 3'd1,
    REG_PLANE_X0     = 3'd2,
    REG_PLANE_X1     = 3'd3,
    REG_PLANE_X2     = 3'd4,
    REG_WIRES0       = 3'd5,
    REG_WIRES1       = 3'd6,
    REG_WIRES2       = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_ADD,
    ACC_SUB
  } acc_mode_t;

  typedef struct packed {
    logic                   clr;
    acc_mode_t              mode;
    logic [SHIFT_W-1:0]     shift;
    logic signed [OP_W-1:0] a;
    logic signed [OP_W-1:0] b;
  } mac_cmd_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_W-1:0] base;
    logic [NUM_AXES-1:0][COORD_W-1:0] dir;
    logic [LEN_W-1:0]                 len_sq;
    logic [CHAN_W-1:0]                chan;
  } wire_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_MUL,
    S_LOAD_WAIT,
    S_LOAD_WR,
    S_CHECK,
    S_FETCH,
    S_READ,
    S_CROSS,
    S_SQ_WAIT,
    S_NLAT,
    S_CMP,
    S_CMP_WAIT,
    S_CMP_EVAL,
    S_DONE
  } nwcf_state_t;

endpackage

// File: hdl/nwcf_wire_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwcf_wire_mem: wire table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nwcf_wire_mem import nwcf_pkg::*; #(
  parameter int DEPTH = DEF_MAX_PLANES * DEF_MAX_WIRES,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic        clk,
  input  logic        we,
  input  logic [AW-1:0] waddr,
  input  wire_entry_t wdata,
  input  logic        re,
  input  logic [AW-1:0] raddr,
  output wire_entry_t rdata
);

  wire_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/nwcf_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwcf_mac: shared multiply-accumulate unit
// 34x34 signed multiply into a product register, then a shifted add or
// subtract into a wide signed accumulator (shift in 32-bit limbs).
// ----------------------------------------------------------------------------
module nwcf_mac import nwcf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_cmd_t                 cmd,
  output logic signed [PROD_W-1:0] prod,
  output logic signed [ACC_W-1:0]  acc
);

  acc_mode_t                mode_q;
  logic [SHIFT_W-1:0]       shift_q;
  logic signed [ACC_W-1:0]  term;

  // multiply stage
  always_ff @(posedge clk) begin
    prod <= $signed(cmd.a) * $signed(cmd.b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q  <= ACC_HOLD;
      shift_q <= '0;
    end else begin
      mode_q  <= cmd.mode;
      shift_q <= cmd.shift;
    end
  end

  // product aligned to its limb
  assign term = ACC_W'(prod) <<< (shift_q * LIMB_W);

  // accumulate stage
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      acc <= '0;
    end else begin
      case (mode_q)
        ACC_ADD: acc <= acc + term;
        ACC_SUB: acc <= acc - term;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/nearest_wire_channel_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_wire_channel_finder: nearest wire channel lookup
// Wire table, point cache and a sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
// A load item writes one wire entry when its plane and wire are in range. A
// query that hits the point cache goes straight to the output handoff. A
// query that misses scans the chosen plane from wire 0: zero-length wires are
// skipped, the first wire of nonzero length needs only its cross product and
// squares, and each later wire also needs a distance comparison, or two when
// it is not closer than the best so far. The per-wire cost is set by the
// single 34x34 multiplier that computes the cross product, its squares and
// the cross-multiplied distance comparisons one 32-bit limb product per
// cycle. The wire table has no clearing pass; the block is ready as soon as
// reset is released. One item is handled at a time; a finished result waits
// in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module nearest_wire_channel_finder import nwcf_pkg::*; #(
  parameter int MAX_PLANES = DEF_MAX_PLANES,
  parameter int MAX_WIRES  = DEF_MAX_WIRES
) (
  input  logic                  clk,
  input  logic                  rst,
  // plane_index, wire_index, point_x, point_y, point_z, dir_x, dir_y, dir_z,
  // channel_number, zero pad
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,   // cmd
  // nearest_channel, zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,   // from_cache
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_PLANES * MAX_WIRES;
  localparam int AW    = $clog2(DEPTH);
  localparam int WC_W  = $clog2(MAX_WIRES + 1);

  localparam logic [4:0] LOAD_LAST  = 5'(NUM_AXES - 1);
  localparam logic [4:0] XS_P       = 5'd0;
  localparam logic [4:0] XS_Q       = 5'd1;
  localparam logic [4:0] XS_ABS     = 5'd2;
  localparam logic [4:0] XS_LL      = 5'd3;
  localparam logic [4:0] XS_LH      = 5'd4;
  localparam logic [4:0] XS_HL      = 5'd5;
  localparam logic [4:0] XS_HH      = 5'd6;
  localparam logic [1:0] COMP_LAST  = 2'(NUM_AXES - 1);
  localparam logic [4:0] CMP_HALF   = 5'(N_LIMBS * D_LIMBS);
  localparam logic [4:0] CMP_LAST   = 5'(2 * N_LIMBS * D_LIMBS - 1);

  function automatic logic [1:0] next_axis(input logic [1:0] a);
    case (a)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  // configuration registers
  logic [CE_W-1:0]           close_enough;
  logic [PCNT_W-1:0]         plane_count;
  logic signed [COORD_W-1:0] plane_x [PLANE_REGS];
  logic [WCNT_W-1:0]         wires_in [PLANE_REGS];

  // current item
  logic [PIDX_W-1:0]         it_plane;
  logic [WIDX_W-1:0]         it_wire;
  logic signed [COORD_W-1:0] it_pt [NUM_AXES];
  logic signed [COORD_W-1:0] it_dir [NUM_AXES];
  logic [CHAN_W-1:0]         it_chan;

  // cache
  logic signed [COORD_W-1:0] last_pt [NUM_AXES];
  logic [CHAN_W-1:0]         cached_channel;
  logic                      cache_valid;

  // scan state
  nwcf_state_t               state, state_next;
  logic [4:0]                step;
  logic [1:0]                comp;
  logic [PIDX_W-1:0]         plane;
  logic [WC_W-1:0]           nw, w;
  logic                      have_best, cmp_last, from_cache_q;
  logic signed [COORD_W:0]   d_vec [NUM_AXES];
  logic signed [COORD_W-1:0] v_vec [NUM_AXES];
  logic [LEN_W-1:0]          cur_d, best_d, last_d;
  logic [CHAN_W-1:0]         cur_chan;
  logic [N_W-1:0]            cur_n, best_n, last_n;
  logic [LEN_W-1:0]          p_reg, m_reg, m_next;

  // output register
  logic                      out_valid;
  logic [CHAN_W-1:0]         out_chan;

  // shared unit and table
  mac_cmd_t                  mac_cmd;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic                      mem_we, mem_re, ld_ok;
  logic [AW-1:0]             waddr, raddr;
  logic [31:0]               waddr32, raddr32;
  wire_entry_t               wdata, rdata;

  // decode helpers
  logic                      hit, cmp_neg, cmp_pos, len_zero;
  logic [COORD_W:0]          diff [NUM_AXES];
  logic [COORD_W:0]          absd [NUM_AXES];
  logic [NUM_AXES-1:0]       near;
  logic [PCNT_W-1:0]         np;
  logic [PIDX_W-1:0]         plane_sel;
  logic [31:0]               nw32;
  logic [1:0]                ax_p, ax_q;
  logic [LIMB_W-1:0]         m_lo, m_hi;
  logic                      cmp_side;
  logic [4:0]                cmp_r;
  logic [2:0]                li;
  logic                      lj;
  logic [N_W-1:0]            ref_n;
  logic [LEN_W-1:0]          ref_d;
  logic [LIMB_W-1:0]         n_limb, d_limb;

  nwcf_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .prod (prod),
    .acc  (acc)
  );

  nwcf_wire_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (mem_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // table addressing
  assign ld_ok   = (32'(it_plane) < 32'(MAX_PLANES)) && (32'(it_wire) < 32'(MAX_WIRES));
  assign waddr32 = 32'(it_plane) * 32'(MAX_WIRES) + 32'(it_wire);
  assign raddr32 = 32'(plane) * 32'(MAX_WIRES) + 32'(w);
  assign waddr   = waddr32[AW-1:0];
  assign raddr   = raddr32[AW-1:0];

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      wdata.base[k] = it_pt[k];
      wdata.dir[k]  = it_dir[k];
    end
    wdata.len_sq = acc[LEN_W-1:0];
    wdata.chan   = it_chan;
  end

  // cache check: strictly inside the tolerance on every axis
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      diff[k] = {it_pt[k][COORD_W-1], it_pt[k]} - {last_pt[k][COORD_W-1], last_pt[k]};
      absd[k] = diff[k][COORD_W] ? ((COORD_W + 1)'(0) - diff[k]) : diff[k];
      near[k] = absd[k] < (COORD_W + 1)'(close_enough);
    end
    hit = cache_valid && (&near);
  end

  // plane choice and wire count
  always_comb begin
    np = (plane_count == '0) ? PCNT_W'(1) : plane_count;
    if (int'(np) > MAX_PLANES) begin
      np = PCNT_W'(MAX_PLANES);
    end
    plane_sel = '0;
    for (int i = 0; i < PLANE_REGS - 1; i++) begin
      if ((i + 1 < int'(np)) && (it_pt[0] < plane_x[i]) && (it_pt[0] > plane_x[i + 1])) begin
        plane_sel = PIDX_W'(i + 1);
      end
    end
    nw32 = (32'(wires_in[plane_sel]) > 32'(MAX_WIRES)) ? 32'(MAX_WIRES)
                                                        : 32'(wires_in[plane_sel]);
  end

  // cross component magnitude, wrapped to 64 bits
  assign m_next = ($signed(p_reg) >= $signed(prod[LEN_W-1:0])) ? p_reg - prod[LEN_W-1:0]
                                                               : prod[LEN_W-1:0] - p_reg;
  assign m_lo   = m_reg[LIMB_W-1:0];
  assign m_hi   = m_reg[2*LIMB_W-1:LIMB_W];
  assign ax_p   = next_axis(comp);
  assign ax_q   = next_axis(ax_p);

  // ratio compare operands: first half adds cur_n*ref_d, second subtracts ref_n*cur_d
  assign cmp_side = (step >= CMP_HALF);
  assign cmp_r    = cmp_side ? step - CMP_HALF : step;
  assign li       = cmp_r[3:1];
  assign lj       = cmp_r[0];
  assign ref_n    = cmp_last ? last_n : best_n;
  assign ref_d    = cmp_last ? last_d : best_d;
  assign n_limb   = cmp_side ? ref_n[li*LIMB_W +: LIMB_W] : cur_n[li*LIMB_W +: LIMB_W];
  assign d_limb   = cmp_side ? cur_d[lj*LIMB_W +: LIMB_W] : ref_d[lj*LIMB_W +: LIMB_W];
  assign cmp_neg  = acc[ACC_W-1];
  assign cmp_pos  = !acc[ACC_W-1] && (acc != '0);
  assign len_zero = (rdata.len_sq == '0);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit commands
  always_comb begin
    state_next    = state;
    mac_cmd.clr   = 1'b0;
    mac_cmd.mode  = ACC_HOLD;
    mac_cmd.shift = '0;
    mac_cmd.a     = '0;
    mac_cmd.b     = '0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          mac_cmd.clr = 1'b1;
          state_next  = (s_tuser == CMD_QUERY) ? S_CHECK : S_LOAD_MUL;
        end
      end
      S_LOAD_MUL: begin
        mac_cmd.mode = ACC_ADD;
        mac_cmd.a    = OP_W'(it_dir[step[1:0]]);
        mac_cmd.b    = OP_W'(it_dir[step[1:0]]);
        if (step == LOAD_LAST) begin
          state_next = S_LOAD_WAIT;
        end
      end
      S_LOAD_WAIT: state_next = S_LOAD_WR;
      S_LOAD_WR: begin
        mem_we     = ld_ok;
        state_next = S_IDLE;
      end
      S_CHECK: state_next = hit ? S_DONE : S_FETCH;
      S_FETCH: begin
        if (w == nw) begin
          state_next = S_DONE;
        end else begin
          mem_re     = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (len_zero) begin
          state_next = S_FETCH;
        end else begin
          mac_cmd.clr = 1'b1;
          state_next  = S_CROSS;
        end
      end
      S_CROSS: begin
        case (step)
          XS_P: begin
            mac_cmd.a = OP_W'(d_vec[ax_p]);
            mac_cmd.b = OP_W'(v_vec[ax_q]);
          end
          XS_Q: begin
            mac_cmd.a = OP_W'(d_vec[ax_q]);
            mac_cmd.b = OP_W'(v_vec[ax_p]);
          end
          XS_LL: begin
            mac_cmd.mode = ACC_ADD;
            mac_cmd.a    = OP_W'(m_lo);
            mac_cmd.b    = OP_W'(m_lo);
          end
          XS_LH: begin
            mac_cmd.mode  = ACC_ADD;
            mac_cmd.shift = SHIFT_W'(1);
            mac_cmd.a     = OP_W'(m_lo);
            mac_cmd.b     = OP_W'(m_hi);
          end
          XS_HL: begin
            mac_cmd.mode  = ACC_ADD;
            mac_cmd.shift = SHIFT_W'(1);
            mac_cmd.a     = OP_W'(m_hi);
            mac_cmd.b     = OP_W'(m_lo);
          end
          XS_HH: begin
            mac_cmd.mode  = ACC_ADD;
            mac_cmd.shift = SHIFT_W'(2);
            mac_cmd.a     = OP_W'(m_hi);
            mac_cmd.b     = OP_W'(m_hi);
            if (comp == COMP_LAST) begin
              state_next = S_SQ_WAIT;
            end
          end
          default: ;
        endcase
      end
      S_SQ_WAIT: state_next = S_NLAT;
      S_NLAT: begin
        if (!have_best) begin
          state_next = S_FETCH;
        end else begin
          mac_cmd.clr = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        mac_cmd.mode  = cmp_side ? ACC_SUB : ACC_ADD;
        mac_cmd.shift = SHIFT_W'(li) + SHIFT_W'(lj);
        mac_cmd.a     = OP_W'(n_limb);
        mac_cmd.b     = OP_W'(d_limb);
        if (step == CMP_LAST) begin
          state_next = S_CMP_WAIT;
        end
      end
      S_CMP_WAIT: state_next = S_CMP_EVAL;
      S_CMP_EVAL: begin
        if (!cmp_last) begin
          if (cmp_neg) begin
            state_next = S_FETCH;
          end else begin
            mac_cmd.clr = 1'b1;
            state_next  = S_CMP;
          end
        end else begin
          state_next = cmp_pos ? S_DONE : S_FETCH;
        end
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      close_enough <= CE_W'(CE_RESET);
      plane_count  <= PCNT_W'(PCNT_RESET);
      for (int i = 0; i < PLANE_REGS; i++) begin
        plane_x[i]  <= '0;
        wires_in[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CLOSE_ENOUGH: close_enough <= cfg_data[CE_W-1:0];
        REG_PLANE_COUNT:  plane_count  <= cfg_data[PCNT_W-1:0];
        REG_PLANE_X0:     plane_x[0]   <= cfg_data;
        REG_PLANE_X1:     plane_x[1]   <= cfg_data;
        REG_PLANE_X2:     plane_x[2]   <= cfg_data;
        REG_WIRES0:       wires_in[0]  <= cfg_data[WCNT_W-1:0];
        REG_WIRES1:       wires_in[1]  <= cfg_data[WCNT_W-1:0];
        REG_WIRES2:       wires_in[2]  <= cfg_data[WCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control, cache and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      step           <= '0;
      comp           <= '0;
      have_best      <= 1'b0;
      cmp_last       <= 1'b0;
      cache_valid    <= 1'b0;
      cached_channel <= '0;
      from_cache_q   <= 1'b0;
      out_valid      <= 1'b0;
      for (int k = 0; k < NUM_AXES; k++) begin
        last_pt[k] <= '0;
      end
    end else begin
      // step counter
      case (state) inside
        S_LOAD_MUL, S_CMP: step <= step + 5'd1;
        S_CROSS:           step <= (step == XS_HH) ? '0 : step + 5'd1;
        default:           step <= '0;
      endcase
      if (state == S_READ) begin
        comp <= '0;
      end else if (state == S_CROSS && step == XS_HH) begin
        comp <= comp + 2'd1;
      end

      if (state == S_LOAD_WR) begin
        cache_valid <= 1'b0;
      end
      if (state == S_CHECK) begin
        from_cache_q <= hit;
        have_best    <= 1'b0;
        if (!hit) begin
          cache_valid <= 1'b1;
          for (int k = 0; k < NUM_AXES; k++) begin
            last_pt[k] <= it_pt[k];
          end
        end
      end
      if (state == S_NLAT) begin
        cmp_last <= 1'b0;
        if (!have_best) begin
          have_best      <= 1'b1;
          cached_channel <= cur_chan;
        end
      end
      if (state == S_CMP_EVAL) begin
        if (!cmp_last) begin
          if (cmp_neg) begin
            cached_channel <= cur_chan;
          end else begin
            cmp_last <= 1'b1;
          end
        end
      end

      // output register
      if (state == S_DONE && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      it_plane <= s_tdata[F_PLANE_LSB +: PIDX_W];
      it_wire  <= s_tdata[F_WIRE_LSB +: WIDX_W];
      it_chan  <= s_tdata[F_CHAN_LSB +: CHAN_W];
      for (int k = 0; k < NUM_AXES; k++) begin
        it_pt[k]  <= s_tdata[F_PT_LSB + k*COORD_W +: COORD_W];
        it_dir[k] <= s_tdata[F_DIR_LSB + k*COORD_W +: COORD_W];
      end
    end
    if (state == S_CHECK) begin
      plane <= plane_sel;
      nw    <= nw32[WC_W-1:0];
      w     <= '0;
    end
    // fetch wire operands
    if (state == S_READ) begin
      if (len_zero) begin
        w <= w + 1'b1;
      end else begin
        for (int k = 0; k < NUM_AXES; k++) begin
          d_vec[k] <= {it_pt[k][COORD_W-1], it_pt[k]}
                      - {rdata.base[k][COORD_W-1], rdata.base[k]};
          v_vec[k] <= rdata.dir[k];
        end
        cur_d    <= rdata.len_sq;
        cur_chan <= rdata.chan;
      end
    end
    if (state == S_CROSS && step == XS_Q) begin
      p_reg <= prod[LEN_W-1:0];
    end
    if (state == S_CROSS && step == XS_ABS) begin
      m_reg <= m_next;
    end
    if (state == S_NLAT) begin
      cur_n <= acc[N_W-1:0];
      if (!have_best) begin
        best_n <= acc[N_W-1:0];
        best_d <= cur_d;
        last_n <= acc[N_W-1:0];
        last_d <= cur_d;
        w      <= w + 1'b1;
      end
    end
    if (state == S_CMP_EVAL) begin
      if (!cmp_last && cmp_neg) begin
        best_n <= cur_n;
        best_d <= cur_d;
        last_n <= cur_n;
        last_d <= cur_d;
        w      <= w + 1'b1;
      end else if (cmp_last && !cmp_pos) begin
        last_n <= cur_n;
        last_d <= cur_d;
        w      <= w + 1'b1;
      end
    end
    if (state == S_DONE && (!out_valid || m_tready)) begin
      out_chan <= cached_channel;
      m_tuser  <= from_cache_q;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'(out_chan);

endmodule

// File: hdl/nwcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwcf_checker: port-level checks of the nearest wire channel finder
// Watches the stream ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module nwcf_checker import nwcf_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one item at a time: busy after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again right after an accept");

  // no result can appear in the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared right after an accept");

  // leaving reset: empty output, ready input
  a_reset_state: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid && s_tready)
    else $error("bad state after reset");

endmodule

bind nearest_wire_channel_finder nwcf_checker u_nwcf_checker (.*);
